// ===== src/qsl_pkg.sv =====
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared helpers for the quicksort block: address width of a store of a
// given number of entries.
// ----------------------------------------------------------------------------
`default_nettype none

package qsl_pkg;

    // Address bits for a store of n entries (at least one bit).
    function automatic int f_addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== src/qsl_in_if.sv =====
// ----------------------------------------------------------------------------
// qsl_in_if
// Input channel: one element of the set per item, flag on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsl_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

`default_nettype wire

// ===== src/qsl_out_if.sv =====
// ----------------------------------------------------------------------------
// qsl_out_if
// Output channel: sorted values, smallest first, flag on the greatest.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsl_out_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

// ===== src/qsl_ram.sv =====
// ----------------------------------------------------------------------------
// qsl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_ram
    import qsl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [f_addr_bits(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]              i_wdata,
    input  wire logic [f_addr_bits(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/quicksort_lomuto.sv =====
// ----------------------------------------------------------------------------
// quicksort_lomuto
// Collects a set of unsigned values, sorts it in place with Lomuto-partition
// quicksort driven from a range stack, and streams it out in ascending order.
// ----------------------------------------------------------------------------
// Load: one item per cycle; the item flagged last (or the one that fills the
//   store) closes the set and input stalls until the set has been emitted.
// Sort: a compare passes S_RD and S_CMP, a swap adds S_SW1 and S_SW2, all
//   bound by the single read and single write port of the element RAM.
// Emit: a RAM read, then an output register load per value, ready permitting.
// Reset (synchronous, active low) empties the store and the range stack.
`default_nettype none

module quicksort_lomuto
    import qsl_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qsl_in_if.sink     i_item,
    qsl_out_if.source  o_result
);

    localparam int IDXW = f_addr_bits(DEPTH);
    localparam int CNTW = f_addr_bits(DEPTH + 1);
    localparam int STKW = 2 * IDXW;

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_POP, S_POP_W, S_PIV, S_RD, S_CMP,
        S_SW1, S_SW2, S_FIN1, S_FIN2, S_EM_RD, S_EM_LD
    } t_state;

    t_state                r_state;
    logic [CNTW-1:0]       r_count;
    logic [CNTW-1:0]       r_n;
    logic [CNTW-1:0]       r_top;
    logic [IDXW-1:0]       r_lo;
    logic [IDXW-1:0]       r_hi;
    logic [IDXW-1:0]       r_wr;
    logic [IDXW-1:0]       r_j;
    logic [IDXW-1:0]       r_k;
    logic [VALUE_BITS-1:0] r_pivot;
    logic [VALUE_BITS-1:0] r_tmp;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_last;

    // element RAM
    logic                  el_we;
    logic [IDXW-1:0]       el_waddr;
    logic [VALUE_BITS-1:0] el_wdata;
    logic [IDXW-1:0]       el_raddr;
    logic [VALUE_BITS-1:0] el_rdata;

    // range stack RAM
    logic                  st_we;
    logic [IDXW-1:0]       st_waddr;
    logic [STKW-1:0]       st_wdata;
    logic [IDXW-1:0]       st_raddr;
    logic [STKW-1:0]       st_rdata;
    logic [IDXW-1:0]       st_lo;
    logic [IDXW-1:0]       st_hi;

    logic                  in_fire;
    logic                  out_fire;
    logic                  close_set;
    logic                  out_free;
    logic                  k_last;
    logic                  push_left;
    logic                  push_right;
    logic                  stack_room;

    qsl_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_BITS)) u_elem (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    qsl_ram #(.DEPTH(DEPTH), .WIDTH(STKW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign st_lo = st_rdata[STKW-1:IDXW];
    assign st_hi = st_rdata[IDXW-1:0];

    assign i_item.ready          = (r_state == S_LOAD);
    assign o_result.valid        = r_out_valid;
    assign o_result.sorted_value = r_out_value;
    assign o_result.last_out     = r_out_last;

    assign in_fire    = i_item.valid && i_item.ready;
    assign out_fire   = r_out_valid && o_result.ready;
    assign close_set  = i_item.last_item || (r_count == CNTW'(DEPTH - 1));
    assign out_free   = !r_out_valid || o_result.ready;
    assign k_last     = ((CNTW'(r_k) + CNTW'(1)) == r_n);
    assign stack_room = (r_top < CNTW'(DEPTH));
    // pivot lands at r_wr; keep only subranges of two or more elements
    assign push_left  = ({1'b0, r_wr} > ({1'b0, r_lo} + (IDXW + 1)'(1)));
    assign push_right = ({1'b0, r_hi} > ({1'b0, r_wr} + (IDXW + 1)'(1)));

    always_comb begin
        el_we    = 1'b0;
        el_waddr = r_wr;
        el_wdata = r_tmp;
        case (r_state)
            S_LOAD: begin
                el_we    = in_fire;
                el_waddr = r_count[IDXW-1:0];
                el_wdata = i_item.value;
            end
            S_SW1: begin
                el_we    = 1'b1;
                el_waddr = r_wr;
                el_wdata = r_tmp;
            end
            S_SW2: begin
                el_we    = 1'b1;
                el_waddr = r_j;
                el_wdata = r_tmp;
            end
            S_FIN1: begin
                el_we    = 1'b1;
                el_waddr = r_hi;
                el_wdata = el_rdata;
            end
            S_FIN2: begin
                el_we    = 1'b1;
                el_waddr = r_wr;
                el_wdata = r_pivot;
            end
            default: begin
                el_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_POP_W: el_raddr = st_hi;
            S_RD:    el_raddr = (r_j == r_hi) ? r_wr : r_j;
            S_CMP:   el_raddr = r_wr;
            S_EM_RD: el_raddr = r_k;
            default: el_raddr = r_j;
        endcase
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_top[IDXW-1:0];
        st_wdata = {r_lo, r_hi};
        st_raddr = r_top[IDXW-1:0] - IDXW'(1);
        case (r_state)
            S_START: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = {IDXW'(0), IDXW'(r_n - CNTW'(1))};
            end
            S_FIN1: begin
                st_we    = push_left && stack_room;
                st_wdata = {r_lo, r_wr - IDXW'(1)};
            end
            S_FIN2: begin
                st_we    = push_right && stack_room;
                st_wdata = {r_wr + IDXW'(1), r_hi};
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_n         <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (close_set) begin
                            r_n     <= r_count + CNTW'(1);
                            r_count <= '0;
                            r_state <= S_START;
                        end else begin
                            r_count <= r_count + CNTW'(1);
                        end
                    end
                end
                S_START: begin
                    r_k <= '0;
                    if (r_n < CNTW'(2)) begin
                        r_top   <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_top   <= CNTW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_top == '0) begin
                        r_state <= S_EM_RD;
                    end else begin
                        r_top   <= r_top - CNTW'(1);
                        r_state <= S_POP_W;
                    end
                end
                S_POP_W: begin
                    if (st_lo >= st_hi) begin
                        r_state <= S_POP;
                    end else begin
                        r_lo    <= st_lo;
                        r_hi    <= st_hi;
                        r_wr    <= st_lo;
                        r_j     <= st_lo;
                        r_state <= S_PIV;
                    end
                end
                S_PIV: begin
                    r_pivot <= el_rdata;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= (r_j == r_hi) ? S_FIN1 : S_CMP;
                end
                S_CMP: begin
                    r_tmp <= el_rdata;
                    if (el_rdata < r_pivot) begin
                        if (r_wr == r_j) begin
                            r_wr    <= r_wr + IDXW'(1);
                            r_j     <= r_j + IDXW'(1);
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_SW1;
                        end
                    end else begin
                        r_j     <= r_j + IDXW'(1);
                        r_state <= S_RD;
                    end
                end
                S_SW1: begin
                    // hold the old entry at wr for the second half of the swap
                    r_tmp   <= el_rdata;
                    r_state <= S_SW2;
                end
                S_SW2: begin
                    r_wr    <= r_wr + IDXW'(1);
                    r_j     <= r_j + IDXW'(1);
                    r_state <= S_RD;
                end
                S_FIN1: begin
                    if (push_left && stack_room) begin
                        r_top <= r_top + CNTW'(1);
                    end
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    if (push_right && stack_room) begin
                        r_top <= r_top + CNTW'(1);
                    end
                    r_state <= S_POP;
                end
                S_EM_RD: begin
                    if (out_free) begin
                        r_state <= S_EM_LD;
                    end
                end
                S_EM_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= el_rdata;
                    r_out_last  <= k_last;
                    r_k         <= r_k + IDXW'(1);
                    r_state     <= k_last ? S_LOAD : S_EM_RD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CNTW'(DEPTH))
        else $error("range stack overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNTW'(DEPTH))
        else $error("load count passed capacity");

    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP || r_state == S_SW1 || r_state == S_SW2)
        |-> (r_lo <= r_wr && r_wr <= r_j && r_j <= r_hi))
        else $error("partition pointers out of order");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_LD && k_last)
        |=> (r_state == S_LOAD && r_out_valid && r_out_last))
        else $error("final item did not end the set");

endmodule

`default_nettype wire
